// ===== rtl/roman_numeral_encoder_top_macros.svh =====
// Assertion macros shared by the roman numeral encoder RTL.
`ifndef ROMAN_NUMERAL_ENCODER_TOP_MACROS_SVH
`define ROMAN_NUMERAL_ENCODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RNE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("roman encoder: implication check failed");
`define RNE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("roman encoder: next-cycle check failed");
`else
`define RNE_ASSERT_IMP(lbl, ante, cons)
`define RNE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/rne_pkg.sv =====
// Types, constants and digit tables for the roman numeral encoder.
package rne_pkg;

  localparam int VALUE_W    = 12;
  localparam int LETTER_W   = 7;
  // one step per decimal place; units fall out of the last step
  localparam int CONV_STEPS = 3;
  localparam int CNT_W      = $clog2(CONV_STEPS);
  localparam int BCD_W      = 16;

  localparam logic [VALUE_W-1:0] ROMAN_LIMIT = 12'd3999;

  localparam logic [LETTER_W-1:0] LET_NONE = 7'h00;
  localparam logic [LETTER_W-1:0] LET_I    = 7'h49;
  localparam logic [LETTER_W-1:0] LET_V    = 7'h56;
  localparam logic [LETTER_W-1:0] LET_X    = 7'h58;
  localparam logic [LETTER_W-1:0] LET_L    = 7'h4C;
  localparam logic [LETTER_W-1:0] LET_C    = 7'h43;
  localparam logic [LETTER_W-1:0] LET_D    = 7'h44;
  localparam logic [LETTER_W-1:0] LET_M    = 7'h4D;

  // decimal places, most significant first
  localparam logic [1:0] PL_TH = 2'd0;
  localparam logic [1:0] PL_HU = 2'd1;
  localparam logic [1:0] PL_TE = 2'd2;
  localparam logic [1:0] PL_UN = 2'd3;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_t;

  typedef struct packed {
    logic       empty;
    logic [1:0] th;
    logic [3:0] hu;
    logic [3:0] te;
    logic [3:0] un;
  } fe_item_t;

  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic sym_t digit_sym(input logic [3:0] d, input logic [1:0] pos);
    sym_t s;
    if (d == 4'd9) begin
      s = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
    end else if (d == 4'd4) begin
      s = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
    end else if (d >= 4'd5) begin
      s = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
    end else begin
      s = SYM_ONE;
    end
    return s;
  endfunction

  // k times the weight of a place; thousands above 3 can never fit
  function automatic logic [VALUE_W-1:0] step_mult(input logic [1:0] step, input int k);
    logic [VALUE_W-1:0] m;
    unique case (step)
      PL_TH:   m = (k <= 3) ? VALUE_W'(k * 1000) : '1;
      PL_HU:   m = VALUE_W'(k * 100);
      default: m = VALUE_W'(k * 10);
    endcase
    return m;
  endfunction

  function automatic logic [3:0] place_digit(input fe_item_t it, input logic [1:0] p);
    logic [3:0] d;
    unique case (p)
      PL_TH:   d = {2'b00, it.th};
      PL_HU:   d = it.hu;
      PL_TE:   d = it.te;
      default: d = it.un;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] place_len(input fe_item_t it, input logic [1:0] p);
    logic [3:0] d;
    d = place_digit(it, p);
    return (p == PL_TH) ? d[2:0] : digit_len(d);
  endfunction

  function automatic logic [LETTER_W-1:0] place_letter(input logic [1:0] p, input sym_t s);
    logic [LETTER_W-1:0] l;
    unique case (p)
      PL_TH: l = LET_M;
      PL_HU: l = (s == SYM_ONE) ? LET_C : ((s == SYM_FIVE) ? LET_D : LET_M);
      PL_TE: l = (s == SYM_ONE) ? LET_X : ((s == SYM_FIVE) ? LET_L : LET_C);
      default: l = (s == SYM_ONE) ? LET_I : ((s == SYM_FIVE) ? LET_V : LET_X);
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/rne_front.sv =====
// Front end: takes a number, classifies it and converts it to decimal digits.
`include "roman_numeral_encoder_top_macros.svh"
module rne_front import rne_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [VALUE_W-1:0] in_value,
  output logic               in_full,
  output logic               q_push,
  output fe_item_t           q_item,
  input  logic               q_full
);

  fe_state_t          state_r, state_nxt;
  logic [VALUE_W-1:0] sh_r, sh_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               empty_r, empty_nxt;
  logic [3:0]         dig;
  logic [VALUE_W-1:0] sub;
  logic [VALUE_W-1:0] diff;

  // one decimal place per cycle: largest multiple of its weight that fits
  always_comb begin
    dig = 4'd0;
    sub = '0;
    for (int k = 1; k < 10; k++) begin
      if (sh_r >= step_mult(cnt_r, k)) begin
        dig = 4'(k);
        sub = step_mult(cnt_r, k);
      end
    end
    diff = sh_r - sub;
  end

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    empty_nxt = empty_r;
    q_push    = 1'b0;
    unique case (state_r)
      FE_IDLE: begin
        if (in_push) begin
          sh_nxt    = in_value;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          empty_nxt = (in_value == '0) || (in_value > ROMAN_LIMIT);
          state_nxt = empty_nxt ? FE_PUSH : FE_CONV;
        end
      end
      FE_CONV: begin
        sh_nxt  = diff;
        cnt_nxt = cnt_r + 1'b1;
        unique case (cnt_r)
          PL_TH:   bcd_nxt[15:12] = dig;
          PL_HU:   bcd_nxt[11:8]  = dig;
          default: begin
            bcd_nxt[7:4] = dig;
            bcd_nxt[3:0] = diff[3:0];
          end
        endcase
        if (cnt_r == CNT_W'(CONV_STEPS - 1)) begin
          state_nxt = FE_PUSH;
        end
      end
      FE_PUSH: begin
        q_push = 1'b1;
        if (!q_full) begin
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    bcd_r   <= bcd_nxt;
    cnt_r   <= cnt_nxt;
    empty_r <= empty_nxt;
  end

  assign in_full      = (state_r != FE_IDLE);
  assign q_item.empty = empty_r;
  assign q_item.th    = bcd_r[13:12];
  assign q_item.hu    = bcd_r[11:8];
  assign q_item.te    = bcd_r[7:4];
  assign q_item.un    = bcd_r[3:0];

  `RNE_ASSERT_IMP(a_fe_conv_nonempty, state_r == FE_CONV, !empty_r)

endmodule

// ===== rtl/rne_fifo.sv =====
// Two-entry queue of classified requests between front and back end.
`include "roman_numeral_encoder_top_macros.svh"
module rne_fifo import rne_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_push,
  input  fe_item_t q_wdata,
  output logic     q_full,
  input  logic     q_pop,
  output fe_item_t q_rdata,
  output logic     q_empty
);

  fe_item_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  `RNE_ASSERT_IMP(a_fifo_bound, 1'b1, cnt_r <= 2'd2)
  `RNE_ASSERT_NEXT(a_fifo_drain, q_pop && cnt_r == 2'd2, cnt_r == 2'd1)

endmodule

// ===== rtl/rne_back.sv =====
// Back end: walks decimal places; one letter per cycle unless output stalls.
`include "roman_numeral_encoder_top_macros.svh"
module rne_back import rne_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  fe_item_t            q_item,
  input  logic                q_empty,
  output logic                q_pop,
  output logic [LETTER_W-1:0] out_letter,
  output logic                out_empty_res,
  output logic                out_last,
  output logic                out_empty,
  input  logic                out_pop
);

  logic                busy_r, busy_nxt;
  fe_item_t            cur_r, cur_nxt;
  logic [1:0]          place_r, place_nxt;
  logic [1:0]          pos_r, pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LETTER_W-1:0] out_letter_r, out_letter_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_last_r, out_last_nxt;
  logic                adv;
  logic [2:0]          cur_len;
  logic                end_place;
  logic                any_after;
  logic [1:0]          next_place;
  logic [1:0]          first_place;
  sym_t                sym;

  assign adv   = !out_valid_r || out_pop;
  assign q_pop = !busy_r && !q_empty;

  always_comb begin
    cur_len   = place_len(cur_r, place_r);
    end_place = ({1'b0, pos_r} + 3'd1) == cur_len;
    sym       = digit_sym(place_digit(cur_r, place_r), pos_r);

    any_after  = 1'b0;
    next_place = place_r;
    for (int i = 3; i >= 0; i--) begin
      if (2'(i) > place_r && place_len(cur_r, 2'(i)) != 3'd0) begin
        any_after  = 1'b1;
        next_place = 2'(i);
      end
    end

    first_place = PL_UN;
    for (int i = 3; i >= 0; i--) begin
      if (place_len(q_item, 2'(i)) != 3'd0) begin
        first_place = 2'(i);
      end
    end
  end

  always_comb begin
    busy_nxt       = busy_r;
    cur_nxt        = cur_r;
    place_nxt      = place_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r;
    out_letter_nxt = out_letter_r;
    out_empty_nxt  = out_empty_r;
    out_last_nxt   = out_last_r;

    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end

    if (!busy_r) begin
      if (!q_empty) begin
        busy_nxt  = 1'b1;
        cur_nxt   = q_item;
        place_nxt = first_place;
        pos_nxt   = 2'd0;
      end
    end else if (adv) begin
      out_valid_nxt = 1'b1;
      if (cur_r.empty) begin
        out_letter_nxt = LET_NONE;
        out_empty_nxt  = 1'b1;
        out_last_nxt   = 1'b1;
        busy_nxt       = 1'b0;
      end else begin
        out_letter_nxt = place_letter(place_r, sym);
        out_empty_nxt  = 1'b0;
        out_last_nxt   = end_place && !any_after;
        if (end_place) begin
          if (any_after) begin
            place_nxt = next_place;
            pos_nxt   = 2'd0;
          end else begin
            busy_nxt = 1'b0;
          end
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    place_r      <= place_nxt;
    pos_r        <= pos_nxt;
    out_letter_r <= out_letter_nxt;
    out_empty_r  <= out_empty_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_letter    = out_letter_r;
  assign out_empty_res = out_empty_r;
  assign out_last      = out_last_r;
  assign out_empty     = !out_valid_r;

  `RNE_ASSERT_IMP(a_be_empty_last, out_valid_r && out_empty_r,
                  out_last_r && out_letter_r == LET_NONE)
  `RNE_ASSERT_IMP(a_be_place_len, busy_r && !cur_r.empty, cur_len != 3'd0)

endmodule

// ===== rtl/roman_numeral_encoder_top.sv =====
// A number is converted, queued and loaded by the back end before its first letter.
// Front end: one number at a time, 3-step decimal digit extraction, skipped if empty.
// Back end loads each request, then emits one letter per cycle unless output stalls.
// A two-entry queue decouples the two, so conversion overlaps letter output.
// Reset: synchronous, active low; clears control state, queue and output valid.
// Top level of the roman numeral encoder.
module roman_numeral_encoder_top import rne_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                in_full,
  output logic [LETTER_W-1:0] out_letter,
  output logic                out_empty_res,
  output logic                out_last,
  output logic                out_empty,
  input  logic                out_pop
);

  fe_item_t fe_item;
  fe_item_t be_item;
  logic     fe_push;
  logic     q_full;
  logic     q_empty;
  logic     be_pop;

  rne_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_value (in_value),
    .in_full  (in_full),
    .q_push   (fe_push),
    .q_item   (fe_item),
    .q_full   (q_full)
  );

  rne_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (fe_push),
    .q_wdata (fe_item),
    .q_full  (q_full),
    .q_pop   (be_pop),
    .q_rdata (be_item),
    .q_empty (q_empty)
  );

  rne_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_item        (be_item),
    .q_empty       (q_empty),
    .q_pop         (be_pop),
    .out_letter    (out_letter),
    .out_empty_res (out_empty_res),
    .out_last      (out_last),
    .out_empty     (out_empty),
    .out_pop       (out_pop)
  );

endmodule

// ===== dv/tb_top.sv =====
// Testbench for roman_numeral_encoder_top: directed table plus random numbers.
module tb_top import rne_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_NUMBERS = 450;
  localparam int CYCLE_LIMIT    = 1500000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_PRINTS     = 20;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_LETTERS,
    CHK_EMPTY
  } row_chk_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    row_chk_t           chk;
    string              letters;
  } numeral_row_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                empty_res;
    logic                last;
  } letter_exp_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                in_full;
  logic [LETTER_W-1:0] out_letter;
  logic                out_empty_res;
  logic                out_last;
  logic                out_empty;
  logic                out_pop = 1'b0;

  letter_exp_t pending_letters[$];
  letter_exp_t head_exp;
  int          err_count = 0;
  int          numbers_sent = 0;
  int          letters_seen = 0;
  int          empties_seen = 0;
  int          cycle_count = 0;
  bit          no_gap_phase = 1'b0;

  numeral_row_t numeral_rows[25] = '{
    '{12'd0,    CHK_EMPTY,   ""},
    '{12'd4000, CHK_EMPTY,   ""},
    '{12'd4095, CHK_EMPTY,   ""},
    '{12'd1,    CHK_LETTERS, "I"},
    '{12'd3999, CHK_LETTERS, "MMMCMXCIX"},
    '{12'd3888, CHK_LETTERS, "MMMDCCCLXXXVIII"},
    '{12'd4,    CHK_LETTERS, "IV"},
    '{12'd9,    CHK_LETTERS, "IX"},
    '{12'd40,   CHK_LETTERS, "XL"},
    '{12'd90,   CHK_LETTERS, "XC"},
    '{12'd400,  CHK_LETTERS, "CD"},
    '{12'd900,  CHK_LETTERS, "CM"},
    '{12'd5,    CHK_LETTERS, "V"},
    '{12'd10,   CHK_LETTERS, "X"},
    '{12'd50,   CHK_LETTERS, "L"},
    '{12'd100,  CHK_LETTERS, "C"},
    '{12'd500,  CHK_LETTERS, "D"},
    '{12'd1000, CHK_LETTERS, "M"},
    '{12'd3000, CHK_LETTERS, "MMM"},
    '{12'd1994, CHK_LETTERS, "MCMXCIV"},
    '{12'd2048, CHK_MODEL,   ""},
    '{12'd1234, CHK_MODEL,   ""},
    '{12'd3998, CHK_MODEL,   ""},
    '{12'd2730, CHK_MODEL,   ""},
    '{12'd1365, CHK_MODEL,   ""}
  };

  roman_numeral_encoder_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_value      (in_value),
    .in_full       (in_full),
    .out_letter    (out_letter),
    .out_empty_res (out_empty_res),
    .out_last      (out_last),
    .out_empty     (out_empty),
    .out_pop       (out_pop)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  function automatic void push_letter(input logic [LETTER_W-1:0] l);
    pending_letters.push_back('{letter: l, empty_res: 1'b0, last: 1'b0});
  endfunction

  function automatic void push_empty_numeral();
    pending_letters.push_back('{letter: LET_NONE, empty_res: 1'b1, last: 1'b1});
  endfunction

  function automatic void push_place(input int unsigned d, input logic [LETTER_W-1:0] one,
                                     input logic [LETTER_W-1:0] five,
                                     input logic [LETTER_W-1:0] ten);
    int unsigned rest;
    rest = d;
    if (d == 9) begin
      push_letter(one);
      push_letter(ten);
    end else if (d == 4) begin
      push_letter(one);
      push_letter(five);
    end else begin
      if (rest >= 5) begin
        push_letter(five);
        rest -= 5;
      end
      repeat (rest) push_letter(one);
    end
  endfunction

  function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
    int unsigned n;
    n = 32'(v);
    if (n == 0 || n > ROMAN_LIMIT) begin
      push_empty_numeral();
    end else begin
      repeat (n / 1000) push_letter(LET_M);
      push_place((n / 100) % 10, LET_C, LET_D, LET_M);
      push_place((n / 10) % 10, LET_X, LET_L, LET_C);
      push_place(n % 10, LET_I, LET_V, LET_X);
      pending_letters[pending_letters.size()-1].last = 1'b1;
    end
  endfunction

  function automatic void push_typed_numeral(input string s);
    byte ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      pending_letters.push_back('{letter: ch[LETTER_W-1:0], empty_res: 1'b0,
                                  last: (i == s.len() - 1)});
    end
  endfunction

  // long forms: digits that take the most letters, or subtractive pairs
  function automatic logic [VALUE_W-1:0] long_form_number();
    int unsigned forms[5] = '{3, 4, 7, 8, 9};
    int unsigned n;
    n = $urandom_range(3, 0) * 1000;
    n += forms[$urandom_range(4, 0)] * 100;
    n += forms[$urandom_range(4, 0)] * 10;
    n += forms[$urandom_range(4, 0)];
    return n[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] pick_number();
    int unsigned r;
    logic [VALUE_W-1:0] v;
    r = $urandom_range(99, 0);
    if (r < 65) begin
      v = VALUE_W'($urandom_range(3999, 1));
    end else if (r < 80) begin
      v = long_form_number();
    end else if (r < 90) begin
      v = ($urandom_range(1, 0) == 0) ? '0 : VALUE_W'($urandom_range(4095, 4000));
    end else begin
      v = VALUE_W'($urandom_range(4095, 0));
    end
    return v;
  endfunction

  function automatic int pick_send_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (no_gap_phase || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    return $urandom_range(80, 30);
  endfunction

  task automatic send_number(input logic [VALUE_W-1:0] v);
    in_push  <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    numbers_sent++;
  endtask

  task automatic idle_input(input int gap);
    if (gap > 0) begin
      in_push  <= 1'b0;
      in_value <= VALUE_W'($urandom_range(4095, 0));
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: pop stretches broken by stalls, mostly short
  initial begin
    int run;
    int stall;
    int unsigned r;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 50) : $urandom_range(12, 1);
      repeat (run) begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
      r = $urandom_range(99, 0);
      if (r < 25) stall = 0;
      else if (r < 80) stall = $urandom_range(3, 1);
      else if (r < 96) stall = $urandom_range(12, 4);
      else stall = $urandom_range(60, 20);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (pending_letters.size() == 0) begin
        report_mismatch($sformatf("unexpected letter 0x%0h empty_res=%0b last=%0b",
                                  out_letter, out_empty_res, out_last));
      end else begin
        head_exp = pending_letters.pop_front();
        if (out_letter !== head_exp.letter || out_empty_res !== head_exp.empty_res ||
            out_last !== head_exp.last) begin
          report_mismatch($sformatf(
            "got letter 0x%0h empty_res=%0b last=%0b, want 0x%0h %0b %0b",
            out_letter, out_empty_res, out_last,
            head_exp.letter, head_exp.empty_res, head_exp.last));
        end
      end
      if (out_empty_res === 1'b1) empties_seen++;
      else letters_seen++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_letters.size());
    $display("FAIL roman_numeral_encoder_top");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (numeral_rows[i]) begin
      send_number(numeral_rows[i].value);
      case (numeral_rows[i].chk)
        CHK_EMPTY:   push_empty_numeral();
        CHK_LETTERS: push_typed_numeral(numeral_rows[i].letters);
        default:     predict_numeral(numeral_rows[i].value);
      endcase
      idle_input(pick_send_gap());
    end

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      logic [VALUE_W-1:0] v;
      if (i % 50 == 0) no_gap_phase = ($urandom_range(3, 0) == 0);
      v = pick_number();
      send_number(v);
      predict_numeral(v);
      idle_input(pick_send_gap());
    end
    in_push <= 1'b0;

    while (pending_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d numbers (%0d from the directed table)", numbers_sent,
             $size(numeral_rows));
    $display("checked %0d letters and %0d empty results, %0d mismatches", letters_seen,
             empties_seen, err_count);
    if (err_count == 0) begin
      $display("PASS roman_numeral_encoder_top");
    end else begin
      $display("FAIL roman_numeral_encoder_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rne_pkg.sv
rtl/rne_front.sv
rtl/rne_fifo.sv
rtl/rne_back.sv
rtl/roman_numeral_encoder_top.sv
dv/tb_top.sv
